@@ design/fourier_series_evaluator_unit_assert.svh @@
// Assertion macros used by the evaluator's top-level RTL file.
`ifndef FOURIER_SERIES_EVALUATOR_UNIT_ASSERT_SVH
`define FOURIER_SERIES_EVALUATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define FSE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("fse assertion failed");
// An antecedent that implies a consequent in the same cycle.
`define FSE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fse implication failed");
// An antecedent that implies a consequent in the next cycle.
`define FSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fse next-cycle implication failed");
`else
`define FSE_ASSERT(lbl, cond)
`define FSE_ASSERT_IMPL(lbl, ante, cons)
`define FSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/fse_pkg.sv @@
// Types and constants shared by the Fourier series evaluator modules.
package fse_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 7;
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 96;
    localparam int TRIG_W    = 17;
    localparam int ACC_W     = 64;
    localparam int PROD_W    = DATA_W + TRIG_W + 1;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    localparam logic [DATA_W-1:0] PERIOD_RECIP_RESET = 32'd65536;
    localparam logic [IDX_W-1:0]  DEGREE_RESET       = 7'd1;

    // Configuration register indexes.
    localparam logic CFG_PERIOD_RECIP = 1'b0;
    localparam logic CFG_DEGREE       = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_EVAL  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CHECK,
        ST_SETUP,
        ST_INIT,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ADDR_INDEX,
        ADDR_ZERO,
        ADDR_HARM
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        addr_sel_t addr_sel;
        logic      phase_mult;
        logic      run_init;
        logic      issue;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic eff_zero;
        logic last_harm;
        logic pipe_busy;
    } stat_t;

endpackage

@@ design/fse_sine_rom.sv @@
// Quarter-wave sine table with two registered read ports.
module fse_sine_rom #(
    parameter int DEPTH = 1024,
    parameter int AW    = 11
) (
    input  logic                          aclk,
    input  logic [AW-1:0]                 addr_a,
    input  logic [AW-1:0]                 addr_b,
    output logic [fse_pkg::TRIG_W-1:0]    data_a,
    output logic [fse_pkg::TRIG_W-1:0]    data_b
);

    typedef logic [fse_pkg::TRIG_W-1:0] tab_t [0:DEPTH];

    // Entry k is 65536*sin(pi/2*k/DEPTH) from a Taylor series in Q2.30.
    function automatic tab_t build_tab();
        tab_t               t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int k = 0; k <= DEPTH; k++) begin
            x    = (fse_pkg::PI_HALF_Q30 * 64'(k)) / 64'(DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2) >> 30;
                // Divide by (2n)(2n+1) for the current term.
                case (n)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    7:       term = term / 64'd210;
                    default: term = term / 64'd272;
                endcase
                if ((n & 1) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            t[k] = fse_pkg::TRIG_W'((sum + 64'sd8192) >>> 14);
        end
        return t;
    endfunction

    localparam tab_t QSINE = build_tab();

    logic [fse_pkg::TRIG_W-1:0] data_a_reg;
    logic [fse_pkg::TRIG_W-1:0] data_b_reg;

    // Registered table reads.
    always_ff @(posedge aclk) begin
        data_a_reg <= QSINE[addr_a];
        data_b_reg <= QSINE[addr_b];
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

@@ design/fse_ctrl.sv @@
// Controller state machine that sequences one transaction at a time.
module fse_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic [fse_pkg::OP_W-1:0]        s_op,
    output logic                            s_tready,
    input  fse_pkg::stat_t                  stat,
    output fse_pkg::cmd_t                   cmd
);

    fse_pkg::state_t state_reg;
    fse_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fse_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fse_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (fse_pkg::op_t'(s_op) == fse_pkg::OP_EVAL) begin
                        state_next = fse_pkg::ST_SETUP;
                    end else begin
                        state_next = fse_pkg::ST_LOOK;
                    end
                end
            end
            fse_pkg::ST_LOOK:  state_next = fse_pkg::ST_CHECK;
            fse_pkg::ST_CHECK: begin
                if (stat.out_free) state_next = fse_pkg::ST_IDLE;
            end
            fse_pkg::ST_SETUP: state_next = fse_pkg::ST_INIT;
            fse_pkg::ST_INIT: begin
                state_next = stat.eff_zero ? fse_pkg::ST_DRAIN : fse_pkg::ST_RUN;
            end
            fse_pkg::ST_RUN: begin
                if (stat.last_harm) state_next = fse_pkg::ST_DRAIN;
            end
            fse_pkg::ST_DRAIN: begin
                if (!stat.pipe_busy) state_next = fse_pkg::ST_DONE;
            end
            fse_pkg::ST_DONE: begin
                if (stat.out_free) state_next = fse_pkg::ST_IDLE;
            end
            default: state_next = fse_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.addr_sel   = fse_pkg::ADDR_INDEX;
        case (state_reg)
            fse_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            fse_pkg::ST_CHECK: cmd.load_out = stat.out_free;
            fse_pkg::ST_SETUP: begin
                cmd.addr_sel   = fse_pkg::ADDR_ZERO;
                cmd.phase_mult = 1'b1;
            end
            fse_pkg::ST_INIT:  cmd.run_init = 1'b1;
            fse_pkg::ST_RUN: begin
                cmd.addr_sel = fse_pkg::ADDR_HARM;
                cmd.issue    = 1'b1;
            end
            fse_pkg::ST_DONE:  cmd.load_out = stat.out_free;
            default: ;
        endcase
    end

endmodule

@@ design/fse_dp.sv @@
// Datapath: configuration, coefficient store, phase and multiply-accumulate, output register.
module fse_dp #(
    parameter int MAX_HARMONICS    = 64,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_index,
    input  logic [fse_pkg::DATA_W-1:0]          cfg_data,
    input  logic [fse_pkg::OP_W-1:0]            s_op,
    input  logic [fse_pkg::S_TDATA_W-1:0]       s_tdata,
    input  fse_pkg::cmd_t                       cmd,
    output fse_pkg::stat_t                      stat,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [fse_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_status
);

    localparam int IW = $clog2(MAX_HARMONICS + 1);
    localparam int CW = (IW > fse_pkg::IDX_W) ? IW : fse_pkg::IDX_W;
    localparam int KW = $clog2(SINE_TABLE_DEPTH);
    localparam int SW = KW + 2;
    localparam int RW = KW + 1;
    localparam int DW = fse_pkg::DATA_W;

    // Configuration registers.
    logic [DW-1:0]              pr_reg;
    logic [fse_pkg::IDX_W-1:0]  deg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_reg  <= fse_pkg::PERIOD_RECIP_RESET;
            deg_reg <= fse_pkg::DEGREE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == fse_pkg::CFG_PERIOD_RECIP) begin
                pr_reg <= cfg_data;
            end else begin
                deg_reg <= cfg_data[fse_pkg::IDX_W-1:0];
            end
        end
    end

    // Effective degree, limited to the store size.
    logic [CW-1:0] eff;
    logic [IW-1:0] eff_i;
    assign eff   = (CW'(deg_reg) > CW'(MAX_HARMONICS)) ? CW'(MAX_HARMONICS) : CW'(deg_reg);
    assign eff_i = IW'(eff);

    // Captured transaction.
    fse_pkg::op_t               op_reg;
    logic [fse_pkg::IDX_W-1:0]  idx_reg;
    logic [DW-1:0]              cin_reg;
    logic [DW-1:0]              sin_reg;
    logic [DW-1:0]              pt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= fse_pkg::op_t'(s_op);
            idx_reg <= s_tdata[6:0];
            cin_reg <= s_tdata[38:7];
            sin_reg <= s_tdata[70:39];
            pt_reg  <= s_tdata[102:71];
        end
    end

    // Harmonic counter and phase accumulator.
    logic [IW-1:0] harm_reg;
    logic [DW-1:0] ph_reg;
    logic [DW-1:0] frac_reg;

    always_ff @(posedge aclk) begin
        if (cmd.phase_mult) begin
            ph_reg <= DW'(pt_reg * pr_reg);
        end
        if (cmd.run_init) begin
            harm_reg <= IW'(1);
            frac_reg <= ph_reg;
        end else if (cmd.issue) begin
            harm_reg <= harm_reg + IW'(1);
            frac_reg <= frac_reg + ph_reg;
        end
    end

    // Coefficient store with valid bits; unwritten entries read as zero.
    logic [DW-1:0]          mem_cos [0:MAX_HARMONICS];
    logic [DW-1:0]          mem_sin [0:MAX_HARMONICS];
    logic [MAX_HARMONICS:0] valid_reg;
    logic [IW-1:0]          addr_a;
    logic [IW-1:0]          waddr;
    logic                   do_write;
    logic [DW-1:0]          rda_cos_reg;
    logic [DW-1:0]          rda_sin_reg;
    logic [DW-1:0]          rdb_cos_reg;
    logic [DW-1:0]          rdb_sin_reg;
    logic                   va_reg;
    logic                   vb_reg;
    logic                   bad;

    always_comb begin
        case (cmd.addr_sel)
            fse_pkg::ADDR_ZERO: addr_a = '0;
            fse_pkg::ADDR_HARM: addr_a = harm_reg;
            default:            addr_a = IW'(idx_reg);
        endcase
    end

    assign waddr    = IW'(idx_reg);
    assign do_write = cmd.load_out && (op_reg == fse_pkg::OP_WRITE) && !bad;

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem_cos[waddr] <= cin_reg;
            mem_sin[waddr] <= (idx_reg == '0) ? '0 : sin_reg;
        end
        rda_cos_reg <= mem_cos[addr_a];
        rda_sin_reg <= mem_sin[addr_a];
        rdb_cos_reg <= mem_cos[eff_i];
        rdb_sin_reg <= mem_sin[eff_i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end else begin
            if (do_write) valid_reg[waddr] <= 1'b1;
            va_reg <= valid_reg[addr_a];
            vb_reg <= valid_reg[eff_i];
        end
    end

    logic [DW-1:0] a_cos;
    logic [DW-1:0] a_sin;
    logic [DW-1:0] b_cos;
    logic [DW-1:0] b_sin;
    assign a_cos = va_reg ? rda_cos_reg : '0;
    assign a_sin = va_reg ? rda_sin_reg : '0;
    assign b_cos = vb_reg ? rdb_cos_reg : '0;
    assign b_sin = vb_reg ? rdb_sin_reg : '0;

    // Index check against the effective degree and the pair stored there.
    assign bad = (CW'(idx_reg) > eff) ||
                 ((CW'(idx_reg) == eff) && (b_cos == '0) && (b_sin == '0));

    // Table addressing: quadrant from the top phase bits, mirrored in odd quadrants.
    logic [SW-1:0] step;
    logic [1:0]    q_s;
    logic [1:0]    q_c;
    logic [KW-1:0] k;
    logic [RW-1:0] rom_addr_s;
    logic [RW-1:0] rom_addr_c;
    logic [fse_pkg::TRIG_W-1:0] rom_s;
    logic [fse_pkg::TRIG_W-1:0] rom_c;

    assign step       = frac_reg[DW-1 -: SW];
    assign q_s        = step[SW-1:SW-2];
    assign q_c        = q_s + 2'd1;
    assign k          = step[KW-1:0];
    assign rom_addr_s = q_s[0] ? (RW'(SINE_TABLE_DEPTH) - RW'(k)) : RW'(k);
    assign rom_addr_c = q_c[0] ? (RW'(SINE_TABLE_DEPTH) - RW'(k)) : RW'(k);

    fse_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH),
        .AW    (RW)
    ) u_rom (
        .aclk   (aclk),
        .addr_a (rom_addr_s),
        .addr_b (rom_addr_c),
        .data_a (rom_s),
        .data_b (rom_c)
    );

    // Multiply-accumulate pipeline: reads, products, accumulate.
    logic s1_v_reg;
    logic s2_v_reg;
    logic neg_s_reg;
    logic neg_c_reg;
    logic signed [fse_pkg::TRIG_W:0]   trig_s;
    logic signed [fse_pkg::TRIG_W:0]   trig_c;
    logic signed [fse_pkg::PROD_W-1:0] prod_c_reg;
    logic signed [fse_pkg::PROD_W-1:0] prod_s_reg;
    logic signed [fse_pkg::ACC_W-1:0]  acc_reg;

    assign trig_s = neg_s_reg ? -$signed({1'b0, rom_s}) : $signed({1'b0, rom_s});
    assign trig_c = neg_c_reg ? -$signed({1'b0, rom_c}) : $signed({1'b0, rom_c});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        neg_s_reg  <= q_s[1];
        neg_c_reg  <= q_c[1];
        prod_c_reg <= $signed(a_cos) * trig_c;
        prod_s_reg <= $signed(a_sin) * trig_s;
        if (cmd.run_init) begin
            acc_reg <= fse_pkg::ACC_W'($signed(a_cos)) <<< 15;
        end else if (s2_v_reg) begin
            acc_reg <= acc_reg + fse_pkg::ACC_W'(prod_c_reg) + fse_pkg::ACC_W'(prod_s_reg);
        end
    end

    // Round half up to Q16.16 and saturate.
    logic signed [fse_pkg::ACC_W-1:0] rnd;
    logic signed [DW-1:0]             series;
    assign rnd = (acc_reg + 64'sd32768) >>> 16;
    always_comb begin
        if (rnd > 64'sd2147483647) begin
            series = 32'sh7fffffff;
        end else if (rnd < -64'sd2147483648) begin
            series = 32'sh80000000;
        end else begin
            series = DW'(rnd);
        end
    end

    // Output register.
    logic                        m_valid_reg;
    logic [fse_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [fse_pkg::M_TDATA_W-1:0] m_data_next;
    logic                        m_status_reg;
    logic                        m_status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result fields for the finished transaction.
    always_comb begin
        m_data_next   = '0;
        m_status_next = 1'b0;
        case (op_reg)
            fse_pkg::OP_EVAL:  m_data_next[31:0] = series;
            fse_pkg::OP_READ: begin
                m_status_next = bad;
                if (!bad) m_data_next[95:32] = {a_sin, a_cos};
            end
            fse_pkg::OP_WRITE: m_status_next = bad;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg   <= m_data_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_status = m_status_reg;

    assign stat.out_free  = !m_valid_reg || m_tready;
    assign stat.eff_zero  = (eff == '0);
    assign stat.last_harm = (harm_reg == eff_i);
    assign stat.pipe_busy = s1_v_reg || s2_v_reg;

endmodule

@@ design/fourier_series_evaluator_unit.sv @@
// Top level of the Fourier series evaluator: controller, datapath and checks.
//
//  Channel  Direction  Handshake            Contents
//  s_       in         s_tvalid/s_tready    op in tuser; index, pair, point in tdata
//  m_       out        m_tvalid/m_tready    value and pair in tdata; status in tuser
//  cfg_     in         cfg_valid/cfg_ready  register index and write data
//
// A write, read or no-op passes a lookup and a check state before the output register.
// An evaluate has setup and init, then one harmonic per cycle, with the degree capped at 64,
// through the coefficient store, the sine table and two multipliers, then drain; when the
// degree is zero it goes from init straight to drain.
// Reset is synchronous and clears the store's valid bits, so it reads as zero.
// A result waiting in the output register does not stop acceptance of the next
// transaction; only delivery of that next result waits for it.
`include "fourier_series_evaluator_unit_assert.svh"
module fourier_series_evaluator_unit #(
    parameter int MAX_HARMONICS    = 64,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // harmonic_index[6:0], cos_coef_in[38:7], sin_coef_in[70:39], point[102:71], zero pad
    input  logic [103:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // series_value[31:0], cos_coef_out[63:32], sin_coef_out[95:64]
    output logic [95:0]   m_tdata,
    // status[0]
    output logic          m_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);

    fse_pkg::cmd_t  cmd;
    fse_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    fse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fse_dp #(
        .MAX_HARMONICS    (MAX_HARMONICS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_op      (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_status  (m_tuser)
    );

    // One transaction at a time: acceptance is followed by a busy cycle.
    `FSE_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    // The output register is loaded only when it is free.
    `FSE_ASSERT_IMPL(a_load_when_free, cmd.load_out, stat.out_free)
    // No harmonic is issued when the effective degree is zero.
    `FSE_ASSERT_IMPL(a_no_issue_deg0, cmd.issue, !stat.eff_zero)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the Fourier series evaluator unit.
module tb_top;
    import fse_pkg::*;

    localparam int NHARM = 64;
    localparam int QDEPTH = 1024;
    localparam bit STAT_OK = 1'b0;
    localparam bit STAT_BAD = 1'b1;

    typedef struct {
        logic [31:0] value;
        logic [31:0] cos_out;
        logic [31:0] sin_out;
        logic        status;
    } series_result_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [103:0]  s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [95:0]   m_tdata;
    logic          m_tuser;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_index;
    logic [31:0]   cfg_data;

    // Predictor state: its own copy of registers, coefficient store and table.
    logic [31:0]        model_recip;
    logic [6:0]         model_degree;
    logic signed [31:0] model_cos [0:NHARM];
    logic signed [31:0] model_sin [0:NHARM];
    int                 quarter_table [0:QDEPTH];

    series_result_t pending_results[$];
    int  fail_count;
    bit  idle_en;
    int  hold_request;

    fourier_series_evaluator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    // Quarter-wave sine entry by integer Taylor series, rounded to Q16.16.
    function automatic int quarter_entry(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x = PI_HALF_Q30 * longint'(k) / QDEPTH;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        return int'((acc + 8192) >>> 14);
    endfunction

    // Full-circle sine at one of 4096 steps.
    function automatic int circle_sine(logic [11:0] step);
        int v;
        v = step[10] ? quarter_table[QDEPTH - step[9:0]] : quarter_table[step[9:0]];
        return step[11] ? -v : v;
    endfunction

    function automatic int unsigned active_degree();
        return (model_degree > NHARM) ? NHARM : model_degree;
    endfunction

    function automatic bit harmonic_bad(logic [6:0] idx);
        int unsigned d;
        d = active_degree();
        if (idx > d) return 1'b1;
        return (idx == d) && model_cos[d] == 0 && model_sin[d] == 0;
    endfunction

    function automatic logic [31:0] series_sum(logic [31:0] point);
        logic [63:0] phase;
        logic [63:0] turn;
        logic [11:0] step;
        longint      acc;
        longint      r;
        phase = {{32{point[31]}}, point} * {32'd0, model_recip};
        acc = longint'(model_cos[0]) * 32768;
        for (int i = 1; i <= active_degree(); i++) begin
            turn = phase * 64'(i);
            step = turn[31:20];
            acc += longint'(model_cos[i]) * circle_sine(step + 12'd1024)
                 + longint'(model_sin[i]) * circle_sine(step);
        end
        acc += 32768;
        r = acc >>> 16;
        if (r > 64'sh7fffffff) return 32'h7fffffff;
        if (r < -64'sh80000000) return 32'h80000000;
        return r[31:0];
    endfunction

    // Updates the store and queues the result of one accepted item.
    task automatic predict_item(op_t op, logic [6:0] idx, logic [31:0] c, logic [31:0] s,
                                logic [31:0] point);
        series_result_t res;
        res = '{32'd0, 32'd0, 32'd0, STAT_OK};
        case (op)
            OP_WRITE: begin
                if (harmonic_bad(idx)) res.status = STAT_BAD;
                else begin
                    model_cos[idx] = c;
                    model_sin[idx] = (idx == 0) ? 32'd0 : s;
                end
            end
            OP_READ: begin
                if (harmonic_bad(idx)) res.status = STAT_BAD;
                else begin
                    res.cos_out = model_cos[idx];
                    res.sin_out = model_sin[idx];
                end
            end
            OP_EVAL: res.value = series_sum(point);
            default: ;
        endcase
        pending_results.push_back(res);
    endtask

    // Sends one item and records its expected result once it is accepted.
    task automatic send_item(op_t op, logic [6:0] idx, logic [31:0] c, logic [31:0] s,
                             logic [31:0] point);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, point, s, c, idx};
        do @(posedge aclk); while (!s_tready);
        predict_item(op, idx, c, s, point);
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PERIOD_RECIP) model_recip = value;
        else model_degree = value[6:0];
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 524288)) - 262144);
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed traffic near the active degree, with some noise.
    task automatic random_traffic(int count);
        int unsigned sel;
        logic [6:0]  idx;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 9);
            idx = 7'($urandom_range(0, active_degree() + 1));
            if (sel < 4) send_item(OP_EVAL, 7'($urandom), $urandom, $urandom, pick_coef());
            else if (sel < 7) send_item(OP_WRITE, idx, pick_coef(), pick_coef(), $urandom);
            else if (sel < 9) send_item(OP_READ, idx, $urandom, $urandom, $urandom);
            else send_item(op_t'($urandom_range(0, 3)), 7'($urandom), $urandom, $urandom,
                           $urandom);
        end
    endtask

    // Reset values: degree one, period one, an empty store.
    task automatic test_reset_state();
        send_item(OP_READ, 7'd0, 32'd0, 32'd0, 32'd0);
        send_item(OP_READ, 7'd1, 32'd0, 32'd0, 32'd0);
        send_item(OP_WRITE, 7'd1, 32'h10000, 32'h10000, 32'd0);
        send_item(OP_EVAL, 7'd0, 32'd0, 32'd0, 32'h00004000);
    endtask

    // Extremes, every operation, saturation and the bad-index rules.
    task automatic test_directed_cases();
        send_item(OP_WRITE, 7'd0, 32'h7fffffff, 32'hffffffff, 32'd0);
        send_item(OP_READ, 7'd0, 32'd0, 32'd0, 32'd0);
        send_item(OP_READ, 7'd127, 32'd0, 32'd0, 32'd0);
        send_item(OP_WRITE, 7'd127, 32'h1, 32'h1, 32'd0);
        send_item(OP_NOP, 7'h7f, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(OP_EVAL, 7'd0, 32'd0, 32'd0, 32'h7fffffff);
        write_register(CFG_DEGREE, 32'd2);
        send_item(OP_WRITE, 7'd1, 32'h7fffffff, 32'h80000000, 32'd0);
        // Positive saturation at the origin, negative once the pair flips.
        send_item(OP_EVAL, 7'd0, 32'd0, 32'd0, 32'd0);
        send_item(OP_WRITE, 7'd0, 32'h80000000, 32'd0, 32'd0);
        send_item(OP_WRITE, 7'd1, 32'h80000000, 32'h7fffffff, 32'd0);
        send_item(OP_EVAL, 7'd0, 32'd0, 32'd0, 32'd0);
        send_item(OP_EVAL, 7'd0, 32'd0, 32'd0, 32'h80000000);
        // Top harmonic is a valid index while it holds a nonzero pair, a bad one once zeroed.
        write_register(CFG_DEGREE, 32'd1);
        send_item(OP_READ, 7'd1, 32'd0, 32'd0, 32'd0);
        send_item(OP_WRITE, 7'd1, 32'd0, 32'd0, 32'd0);
        send_item(OP_READ, 7'd1, 32'd0, 32'd0, 32'd0);
        write_register(CFG_PERIOD_RECIP, 32'd0);
        send_item(OP_EVAL, 7'd0, 32'd0, 32'd0, 32'h12345678);
    endtask

    // Random traffic under several register settings, extremes included.
    task automatic test_config_sweep();
        logic [31:0] recips [5];
        logic [31:0] degrees [6];
        recips = '{32'd1, 32'hffffffff, 32'h00010000, 32'd0, $urandom};
        degrees = '{32'd64, 32'd1, 32'd127, 32'd0, 32'd65, 32'($urandom_range(2, 63))};
        foreach (recips[i]) begin
            write_register(CFG_PERIOD_RECIP, recips[i]);
            write_register(CFG_DEGREE, degrees[i]);
            random_traffic(160);
        end
        write_register(CFG_DEGREE, degrees[5]);
        random_traffic(60);
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        write_register(CFG_DEGREE, 32'd8);
        hold_request = 400;
        random_traffic(40);
    endtask

    // Sender pauses until everything is back, then resumes.
    task automatic test_sender_pause();
        random_traffic(40);
        drain_results();
        random_traffic(40);
    endtask

    task automatic test_final_no_idle();
        write_register(CFG_DEGREE, 32'd64);
        write_register(CFG_PERIOD_RECIP, $urandom);
        idle_en = 1'b0;
        random_traffic(120);
    endtask

    // Receiver: random stall bursts plus a long hold on request.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compares each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        series_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $error("series_value expected %h actual %h", want.value, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.cos_out) begin
                    $error("cos_coef_out expected %h actual %h", want.cos_out, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== want.sin_out) begin
                    $error("sin_coef_out expected %h actual %h", want.sin_out, m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_NOP;
        cfg_valid = 1'b0;
        cfg_index = CFG_PERIOD_RECIP;
        cfg_data = '0;
        fail_count = 0;
        idle_en = 1'b1;
        hold_request = 0;
        model_recip = PERIOD_RECIP_RESET;
        model_degree = DEGREE_RESET;
        for (int i = 0; i <= NHARM; i++) begin
            model_cos[i] = 0;
            model_sin[i] = 0;
        end
        for (int k = 0; k <= QDEPTH; k++) quarter_table[k] = quarter_entry(k);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_directed_cases();
        test_config_sweep();
        test_backpressure();
        test_sender_pause();
        test_final_no_idle();
        drain_results();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/fse_pkg.sv
design/fse_sine_rom.sv
design/fse_ctrl.sv
design/fse_dp.sv
design/fourier_series_evaluator_unit.sv
verif/tb_top.sv
